### design/bwi_pkg.sv
// Shared types and constants for the box window index iterator.
// Used by the front end, the back end and the top unit; depends on nothing.
package bwi_pkg;

    // item kinds carried on s_tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // register map, one 32-bit word each
    localparam int NUM_REGS = 8;
    localparam int ADDR_W   = 5;
    localparam int APB_DW   = 32;
    localparam logic [2:0] REG_NUM_DIMS    = 3'd0;
    localparam logic [2:0] REG_DUAL_MASK   = 3'd1;
    localparam logic [2:0] REG_DIM_SIZE_A  = 3'd2;
    localparam logic [2:0] REG_DIM_SIZE_B  = 3'd3;
    localparam logic [2:0] REG_DIM_SIZE_C  = 3'd4;
    localparam logic [2:0] REG_INV_SCALE_A = 3'd5;
    localparam logic [2:0] REG_INV_SCALE_B = 3'd6;
    localparam logic [2:0] REG_INV_SCALE_C = 3'd7;

    // field widths
    localparam int CENTRE_W   = 24;
    localparam int RADIUS_W   = 24;
    localparam int SCALE_W    = 24;
    localparam int SIZE_REG_W = 11;
    localparam int NUM_CENTRE = 3;
    localparam int IN_DATA_W  = NUM_CENTRE * CENTRE_W + RADIUS_W;
    localparam int INDEX_W    = 30;
    localparam int OUT_DATA_W = 32;

    // bound arithmetic: Q.8 offset times Q8.16 scale gives Q.24
    localparam int FRAC_BITS = 24;
    localparam int Q_W       = CENTRE_W + 2;
    localparam int PROD_W    = Q_W + SCALE_W + 1;
    localparam int BOUND_W   = PROD_W - 1 - FRAC_BITS + 1;

    // header of a command passed from the front end to the back end
    typedef struct packed {
        logic start;
        logic empty;
    } bwi_cmd_t;

endpackage

### design/bwi_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on nothing but its width parameter.
module bwi_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         avail
);
    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full     = count_reg == 2'd2;
    assign avail    = count_reg != 2'd0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop && avail) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if ((push && !full) && !(pop && avail)) begin
            count_next = count_reg + 2'd1;
        end else if (!(push && !full) && (pop && avail)) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/bwi_front.sv
// Front end: accepts items, classifies them and turns a start item into window bounds.
// Depends on bwi_pkg; feeds bwi_queue.
module bwi_front
    import bwi_pkg::*;
#(
    parameter int MAX_DIMS  = 3,
    parameter int SIZE_BITS = 10,
    parameter int DW        = 2,
    parameter int QW        = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic [DW-1:0]        last_dim,
    input  logic [MAX_DIMS-1:0]  dual,
    input  logic [SIZE_BITS:0]   dim_size [MAX_DIMS],
    input  logic [SCALE_W-1:0]   inv_scale [MAX_DIMS],
    input  logic                 q_full,
    output logic                 q_push,
    output logic [QW-1:0]        q_data
);
    localparam int WB = SIZE_BITS + 1;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_FIN  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic                 op_reg;
    logic [IN_DATA_W-1:0] tdata_reg;
    logic [DW-1:0]        dim_reg, dim_next;
    logic                 side_reg, side_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [DW-1:0]        pdim_reg;
    logic                 pside_reg;
    logic                 pvld_reg;
    logic [WB-1:0]        lo_reg [MAX_DIMS];
    logic [WB-1:0]        hi_reg [MAX_DIMS];

    logic [CENTRE_W-1:0]  centre [MAX_DIMS];
    logic [Q_W-1:0]       q_val;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    pm1;
    logic [BOUND_W-1:0]   ceil_val;
    logic [BOUND_W-1:0]   size_ext;
    logic [BOUND_W-1:0]   clamp_val;
    logic [WB-1:0]        bound_val;
    logic                 empty;
    bwi_cmd_t             cmd;

    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_centre
        assign centre[d] = tdata_reg[(d % NUM_CENTRE) * CENTRE_W +: CENTRE_W];
    end

    // offset c-r or c+r and its product with the scale
    always_comb begin
        logic [Q_W-1:0] c_ext;
        logic [Q_W-1:0] r_ext;
        c_ext = {{(Q_W - CENTRE_W){centre[dim_reg][CENTRE_W-1]}}, centre[dim_reg]};
        r_ext = Q_W'(tdata_reg[NUM_CENTRE * CENTRE_W +: RADIUS_W]);
        q_val = side_reg ? (c_ext + r_ext) : (c_ext - r_ext);
        prod  = {{(PROD_W - Q_W){q_val[Q_W-1]}}, q_val} * PROD_W'(inv_scale[dim_reg]);
    end

    // ceiling of the registered product, saturated to 0..size; a dimension that is not radius-limited takes 0 or size
    always_comb begin
        pm1       = prod_reg - PROD_W'(1);
        ceil_val  = {1'b0, pm1[PROD_W-2:FRAC_BITS]} + BOUND_W'(1);
        size_ext  = BOUND_W'(dim_size[pdim_reg]);
        clamp_val = (ceil_val > size_ext) ? size_ext : ceil_val;
        if (prod_reg[PROD_W-1] || prod_reg == '0) begin
            clamp_val = '0;
        end
        bound_val = WB'(clamp_val);
        if (!dual[pdim_reg]) begin
            bound_val = pside_reg ? dim_size[pdim_reg] : '0;
        end
    end

    always_comb begin
        empty = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (DW'(d) <= last_dim && lo_reg[d] >= hi_reg[d]) begin
                empty = 1'b1;
            end
        end
        cmd.start = op_reg == OP_START;
        cmd.empty = empty;
        q_data = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            q_data[d * WB +: WB]              = lo_reg[d];
            q_data[(MAX_DIMS + d) * WB +: WB] = hi_reg[d];
        end
        q_data[2 * MAX_DIMS * WB +: $bits(bwi_cmd_t)] = cmd;
    end

    assign s_tready = state_reg == F_IDLE;
    assign q_push   = (state_reg == F_PUSH) && !q_full;

    always_comb begin
        state_next = state_reg;
        dim_next   = dim_reg;
        side_next  = side_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    dim_next   = '0;
                    side_next  = 1'b0;
                    state_next = (s_tuser == OP_START) ? F_MUL : F_PUSH;
                end
            end
            F_MUL: begin
                if (side_reg && dim_reg == last_dim) begin
                    state_next = F_FIN;
                end else if (side_reg) begin
                    dim_next  = dim_reg + DW'(1);
                    side_next = 1'b0;
                end else begin
                    side_next = 1'b1;
                end
            end
            F_FIN: begin
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            pvld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pvld_reg  <= state_reg == F_MUL;
        end
    end

    always_ff @(posedge aclk) begin
        dim_reg  <= dim_next;
        side_reg <= side_next;
        if (s_tvalid && s_tready) begin
            tdata_reg <= s_tdata;
            op_reg    <= s_tuser;
        end
        if (state_reg == F_MUL) begin
            prod_reg  <= prod;
            pdim_reg  <= dim_reg;
            pside_reg <= side_reg;
        end
        if (pvld_reg) begin
            if (pside_reg) begin
                hi_reg[pdim_reg] <= bound_val;
            end else begin
                lo_reg[pdim_reg] <= bound_val;
            end
        end
    end

endmodule

### design/bwi_back.sv
// Back end: holds the window, forms linear indices and advances the odometer.
// Depends on bwi_pkg; drains bwi_queue and drives the result channel.
module bwi_back
    import bwi_pkg::*;
#(
    parameter int MAX_DIMS  = 3,
    parameter int SIZE_BITS = 10,
    parameter int DW        = 2,
    parameter int QW        = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_avail,
    input  logic [QW-1:0]         q_data,
    output logic                  q_pop,
    input  logic [DW-1:0]         last_dim,
    input  logic [SIZE_BITS:0]    dim_size [MAX_DIMS],
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);
    localparam int WB  = SIZE_BITS + 1;
    localparam int MW  = INDEX_W + WB;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_IDX  = 2'd1;
    localparam logic [1:0] B_EMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [WB-1:0]      low_reg  [MAX_DIMS];
    logic [WB-1:0]      pos_reg  [MAX_DIMS];
    logic [WB-1:0]      high_reg [MAX_DIMS];
    logic               iter_reg;
    logic [DW-1:0]      dim_reg;
    logic [INDEX_W-1:0] acc_reg;
    logic               out_vld_reg;
    logic [INDEX_W-1:0] out_idx_reg;
    logic               out_ok_reg;

    bwi_cmd_t           cmd;
    logic               out_free;
    logic [MW-1:0]      mac;
    logic [WB-1:0]      pos_adv [MAX_DIMS];
    logic               iter_adv;
    logic               load_start;
    logic               emit_zero;
    logic               emit_idx;

    assign cmd      = q_data[2 * MAX_DIMS * WB +: $bits(bwi_cmd_t)];
    assign out_free = !out_vld_reg || m_tready;

    assign q_pop      = (state_reg == B_IDLE) && q_avail && out_free;
    assign load_start = q_pop && cmd.start;
    assign emit_zero  = q_pop && (cmd.start || !iter_reg);
    assign emit_idx   = (state_reg == B_EMIT) && out_free;

    // one multiply-accumulate step of the row-major index per cycle
    assign mac = MW'(acc_reg) * MW'(dim_size[dim_reg]) + MW'(pos_reg[dim_reg]);

    // odometer: last dimension fastest, wrap to the low bound and carry outward
    always_comb begin
        logic          carry;
        logic [WB-1:0] inc;
        carry = 1'b1;
        inc   = '0;
        for (int i = MAX_DIMS - 1; i >= 0; i--) begin
            pos_adv[i] = pos_reg[i];
            if (carry && DW'(i) <= last_dim) begin
                inc = pos_reg[i] + WB'(1);
                if (inc < high_reg[i] || i == 0) begin
                    pos_adv[i] = inc;
                    carry      = 1'b0;
                end else begin
                    pos_adv[i] = low_reg[i];
                end
            end
        end
        iter_adv = pos_adv[0] < high_reg[0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_pop && !cmd.start && iter_reg) begin
                    state_next = B_IDX;
                end
            end
            B_IDX: begin
                if (dim_reg == last_dim) begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            iter_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int d = 0; d < MAX_DIMS; d++) begin
                low_reg[d]  <= '0;
                pos_reg[d]  <= '0;
                high_reg[d] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (emit_zero || emit_idx) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (load_start) begin
                // only the dimensions in use take the new window
                for (int d = 0; d < MAX_DIMS; d++) begin
                    if (DW'(d) <= last_dim) begin
                        low_reg[d]  <= q_data[d * WB +: WB];
                        pos_reg[d]  <= q_data[d * WB +: WB];
                        high_reg[d] <= q_data[(MAX_DIMS + d) * WB +: WB];
                    end
                end
                iter_reg <= !cmd.empty;
            end else if (emit_idx) begin
                for (int d = 0; d < MAX_DIMS; d++) begin
                    pos_reg[d] <= pos_adv[d];
                end
                iter_reg <= iter_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_IDLE) begin
            dim_reg <= '0;
            acc_reg <= '0;
        end else if (state_reg == B_IDX) begin
            dim_reg <= dim_reg + DW'(1);
            acc_reg <= mac[INDEX_W-1:0];
        end
        if (emit_zero) begin
            out_idx_reg <= '0;
            out_ok_reg  <= 1'b0;
        end else if (emit_idx) begin
            out_idx_reg <= acc_reg;
            out_ok_reg  <= 1'b1;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_DATA_W'(out_idx_reg);
    assign m_tuser  = out_ok_reg;

`ifndef ASSERT_OFF
    a_zero_when_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !out_ok_reg |-> out_idx_reg == '0)
        else $error("result without a position carries a nonzero index");

    a_pos_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg |-> pos_reg[0] < high_reg[0])
        else $error("iterating with outer position past the window");

    a_emit_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_EMIT) && out_free |=> out_vld_reg && out_ok_reg)
        else $error("index emit did not reach the output register");
`endif

endmodule

### design/box_window_index_iterator_unit.sv
// Box window index iterator: turns window queries into streams of row-major indices.
// Usage:
//   Input stream s_*: s_tuser is the kind (0 = start, 1 = next); s_tdata carries
//   centre_a [23:0], centre_b [47:24], centre_c [71:48], search_radius [95:72].
//   A start item latches a box window (bounds from centre, radius and inv_scale per
//   radius-limited dimension, full extent otherwise) and returns index 0, flag 0.
//   Each next item returns the current linear index with m_tuser high and steps the
//   odometer (last dimension fastest); once the window is exhausted, or if it is
//   empty, a next item returns index 0 with m_tuser low.
//   The user must write registers via the APB port only with no item in flight; unenforced.
// Timing:
//   The front end takes a new item only once the last one is pushed to the queue; a
//   start first forms its bounds (one bound multiply per cycle, two per dimension used).
//   The back end forms an index with one multiply-accumulate per dimension, then emits
//   it; a start ack or exhausted reply is emitted straight from the queue pop.
//   A two-entry queue parts the two ends, and the result register holds while
//   m_tready is low, so input keeps flowing until the queue fills.
//   aresetn (synchronous, active low) restores register defaults and clears the
//   window and the iterating flag; no clearing pass is needed.
module box_window_index_iterator_unit
    import bwi_pkg::*;
#(
    parameter int MAX_DIMS  = 3,
    parameter int SIZE_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // centre_a, centre_b, centre_c, search_radius
    input  logic                  s_tuser,   // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // index, zero fill
    output logic                  m_tuser,   // index_valid
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);
    localparam int WB       = SIZE_BITS + 1;
    localparam int EFF_DIMS = (MAX_DIMS < 3) ? MAX_DIMS : 3;
    localparam int DW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int QW       = $bits(bwi_cmd_t) + 2 * MAX_DIMS * WB;
    localparam int CW       = (WB > SIZE_REG_W) ? WB : SIZE_REG_W;

    logic [1:0]            num_dims_reg;
    logic [2:0]            dual_mask_reg;
    logic [SIZE_REG_W-1:0] size_regs  [3];
    logic [SCALE_W-1:0]    scale_regs [3];

    logic [2:0]            reg_idx;
    logic [1:0]            nd_eff;
    logic [DW-1:0]         last_dim;
    logic [MAX_DIMS-1:0]   dual;
    logic [WB-1:0]         dim_size  [MAX_DIMS];
    logic [SCALE_W-1:0]    inv_scale [MAX_DIMS];

    logic                  q_push, q_full, q_pop, q_avail;
    logic [QW-1:0]         q_wdata, q_rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dims_reg  <= 2'd2;
            dual_mask_reg <= 3'd3;
            for (int i = 0; i < 3; i++) begin
                size_regs[i]  <= SIZE_REG_W'(1);
                scale_regs[i] <= SCALE_W'(65536);
            end
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_NUM_DIMS:    num_dims_reg  <= pwdata[1:0];
                REG_DUAL_MASK:   dual_mask_reg <= pwdata[2:0];
                REG_DIM_SIZE_A:  size_regs[0]  <= pwdata[SIZE_REG_W-1:0];
                REG_DIM_SIZE_B:  size_regs[1]  <= pwdata[SIZE_REG_W-1:0];
                REG_DIM_SIZE_C:  size_regs[2]  <= pwdata[SIZE_REG_W-1:0];
                REG_INV_SCALE_A: scale_regs[0] <= pwdata[SCALE_W-1:0];
                REG_INV_SCALE_B: scale_regs[1] <= pwdata[SCALE_W-1:0];
                REG_INV_SCALE_C: scale_regs[2] <= pwdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NUM_DIMS:    prdata = APB_DW'(num_dims_reg);
            REG_DUAL_MASK:   prdata = APB_DW'(dual_mask_reg);
            REG_DIM_SIZE_A:  prdata = APB_DW'(size_regs[0]);
            REG_DIM_SIZE_B:  prdata = APB_DW'(size_regs[1]);
            REG_DIM_SIZE_C:  prdata = APB_DW'(size_regs[2]);
            REG_INV_SCALE_A: prdata = APB_DW'(scale_regs[0]);
            REG_INV_SCALE_B: prdata = APB_DW'(scale_regs[1]);
            REG_INV_SCALE_C: prdata = APB_DW'(scale_regs[2]);
            default:         prdata = '0;
        endcase
    end

    // zero dimensions act as one; cap at what the window storage holds
    always_comb begin
        nd_eff = num_dims_reg;
        if (nd_eff == 2'd0) begin
            nd_eff = 2'd1;
        end
        if (nd_eff > 2'(EFF_DIMS)) begin
            nd_eff = 2'(EFF_DIMS);
        end
        last_dim = DW'(nd_eff - 2'd1);
    end

    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
        logic [CW-1:0] raw;
        logic [CW-1:0] limit;
        assign raw          = CW'(size_regs[d % 3]);
        assign limit        = CW'(1) << SIZE_BITS;
        assign dim_size[d]  = WB'((raw > limit) ? limit : raw);
        assign inv_scale[d] = scale_regs[d % 3];
        if (d < 3) begin : g_mask
            assign dual[d] = dual_mask_reg[d];
        end else begin : g_nomask
            assign dual[d] = 1'b0;
        end
    end

    bwi_front #(
        .MAX_DIMS (MAX_DIMS),
        .SIZE_BITS(SIZE_BITS),
        .DW       (DW),
        .QW       (QW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .last_dim (last_dim),
        .dual     (dual),
        .dim_size (dim_size),
        .inv_scale(inv_scale),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    bwi_queue #(
        .W(QW)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_wdata),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (q_rdata),
        .avail    (q_avail)
    );

    bwi_back #(
        .MAX_DIMS (MAX_DIMS),
        .SIZE_BITS(SIZE_BITS),
        .DW       (DW),
        .QW       (QW)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_avail (q_avail),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .last_dim(last_dim),
        .dim_size(dim_size),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
